FILE: rtl/rtti_pkg.sv
// shared types and constants for the radix text-to-integer unit
package rtti_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned RADIX_W     = 5;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
  localparam logic [DIGIT_W-1:0] LETTER_BASE = 4'd10;

  typedef enum logic [2:0] {
    KIND_SPACE,
    KIND_MINUS,
    KIND_PLUS,
    KIND_DIGIT,
    KIND_OTHER
  } char_kind_t;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    char_kind_t           kind;
    logic [DIGIT_W-1:0]   digit;
    logic [RADIX_W-1:0]   radix;
    logic                 radix_ok;
    logic                 last;
  } entry_t;

endpackage

FILE: rtl/radix_text_to_integer_unit.sv
// top level of the radix text-to-integer unit
//
// characters enter one per transaction on in_character with in_last_char
// marking the final one; one signed 32-bit result leaves on out_value per
// text, after its final character. cfg_we with cfg_wdata sets the radix
// (2..16 valid, anything else gives zero), reset value 10; write it only
// while no text is in flight.
// a transaction is taken when valid is high and stall is low on a channel.
// throughput: one character per cycle while in_stall is low, sustained by
// one 32x5 multiply-add per cycle in the back end.
// a final character waits in the queue behind any characters ahead of it;
// the back end then pops it and registers its result in out_value.
// in_stall rises only when the queue between front and back end is full;
// a stalled result holds in the output register while further characters
// are taken and non-final ones still parsed; a final one waits at the head.
// synchronous active-low reset clears the parse state, the queue, the
// output valid and sets the radix back to 10.
module radix_text_to_integer_unit
  import rtti_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [RADIX_W-1:0]        cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CHAR_W-1:0]         in_character,
  input  logic                      in_last_char,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_value
);

  logic [RADIX_W-1:0] radix_r;
  entry_t             front_entry;
  entry_t             head_entry;
  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_wdata;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  rtti_front u_front (
    .in_character (in_character),
    .in_last_char (in_last_char),
    .radix        (radix_r),
    .entry        (front_entry)
  );

  rtti_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  rtti_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value)
  );

endmodule

FILE: rtl/rtti_front.sv
// front end: accepts characters and classifies them into queue entries
module rtti_front
  import rtti_pkg::*;
(
  input  logic [CHAR_W-1:0]  in_character,
  input  logic               in_last_char,
  input  logic [RADIX_W-1:0] radix,
  output entry_t             entry
);

  logic               radix_ok;
  logic [DIGIT_W-1:0] digit;
  logic               is_hex;

  always_comb begin
    radix_ok = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
    is_hex   = 1'b1;
    digit    = '0;
    if ((in_character >= CH_ZERO) && (in_character <= CH_NINE)) begin
      digit = DIGIT_W'(in_character - CH_ZERO);
    end else if ((in_character >= CH_LA) && (in_character <= CH_LF)) begin
      digit = DIGIT_W'(in_character - CH_LA) + LETTER_BASE;
    end else if ((in_character >= CH_UA) && (in_character <= CH_UF)) begin
      digit = DIGIT_W'(in_character - CH_UA) + LETTER_BASE;
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    entry.digit    = digit;
    entry.radix    = radix;
    entry.radix_ok = radix_ok;
    entry.last     = in_last_char;
    if ((in_character == CH_SPACE) ||
        ((in_character >= CH_TAB) && (in_character <= CH_CR))) begin
      entry.kind = KIND_SPACE;
    end else if (in_character == CH_MINUS) begin
      entry.kind = KIND_MINUS;
    end else if (in_character == CH_PLUS) begin
      entry.kind = KIND_PLUS;
    end else if (is_hex && radix_ok && ({1'b0, digit} < radix)) begin
      entry.kind = KIND_DIGIT;
    end else begin
      entry.kind = KIND_OTHER;
    end
  end

endmodule

FILE: rtl/rtti_queue.sv
// short queue of classified characters between front and back end
module rtti_queue
  import rtti_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head_entry
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: rtl/rtti_back.sv
// back end: parse state, digit multiply-add and result register
module rtti_back
  import rtti_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      head_valid,
  input  entry_t                    head_entry,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_value
);

  phase_t                      phase_r, phase_nxt, phase_step;
  logic [VALUE_W-1:0]          acc_r, acc_nxt, acc_step;
  logic                        neg_r, neg_nxt, neg_step;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0]   out_value_r, out_value_nxt;
  logic [VALUE_W-1:0]          prod;
  logic [VALUE_W-1:0]          acc_digit;
  logic                        out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = head_valid && (!head_entry.last || out_free);
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  assign prod      = acc_r * VALUE_W'(head_entry.radix);
  assign acc_digit = prod + VALUE_W'(head_entry.digit);

  // next state of the parse for the character at the queue head
  always_comb begin
    phase_step = phase_r;
    acc_step   = acc_r;
    neg_step   = neg_r;
    case (phase_r)
      PH_SKIP: begin
        case (head_entry.kind)
          KIND_SPACE: phase_step = PH_SKIP;
          KIND_MINUS: begin
            neg_step   = 1'b1;
            phase_step = PH_DIGITS;
          end
          KIND_PLUS:  phase_step = PH_DIGITS;
          KIND_DIGIT: begin
            acc_step   = acc_digit;
            phase_step = PH_DIGITS;
          end
          default:    phase_step = PH_DONE;
        endcase
      end
      PH_DIGITS: begin
        if (head_entry.kind == KIND_DIGIT) begin
          acc_step = acc_digit;
        end else begin
          phase_step = PH_DONE;
        end
      end
      default: phase_step = phase_r;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    if (pop) begin
      if (head_entry.last) begin
        phase_nxt = PH_SKIP;
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
      end else begin
        phase_nxt = phase_step;
        acc_nxt   = acc_step;
        neg_nxt   = neg_step;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    if (pop && head_entry.last) begin
      out_valid_nxt = 1'b1;
      if (!head_entry.radix_ok) begin
        out_value_nxt = '0;
      end else if (neg_step) begin
        out_value_nxt = VALUE_W'('0 - acc_step);
      end else begin
        out_value_nxt = acc_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SKIP;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
  end

endmodule
